[hw/rtl/vrp_pkg.sv]
// ---------------------------------------------------------------------------
// vrp_pkg: shared types and constants for the vertex rotate/project core
// Field widths, fixed-point formats, register indexes, the matrix, view
// and queue item types used by the front end, the queue and the back end.
// ---------------------------------------------------------------------------
package vrp_pkg;

   // Near plane distance in whole units
   localparam int NEAR_DEPTH_DEF = 100;
   localparam int NEAR_W         = 16;

   // Field and datapath widths
   localparam int PT_W      = 24;   // Q16.8 vertex coordinate
   localparam int PT_FRAC   = 8;
   localparam int TERM_W    = 16;   // Q2.14 matrix term
   localparam int PROD_W    = 40;   // term * coordinate
   localparam int ACC_W     = 42;   // sum of three products
   localparam int SCALE_W   = 16;
   localparam int SC_W      = 59;   // accumulator * scale
   localparam int VSHIFT    = 22;
   localparam int V_W       = 38;   // transformed coordinate
   localparam int A_W       = 55;   // NEAR * coordinate, divider dividend
   localparam int DS_W      = 37;   // divisor (positive depth)
   localparam int SCR_W     = 16;
   localparam int S16_MAX   = 32767;
   localparam int S16_MIN   = -32768;
   localparam int ONE_Q14   = 16384;

   // Front to back queue
   localparam int Q_DEPTH   = 4;
   localparam int QA_W      = 2;

   // Matrix rebuild after reset or a register write
   localparam int SETUP_CYCLES = 3;
   localparam int CNT_W        = 2;

   // Register port
   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS,
      CSR_COS,
      CSR_SIN,
      CSR_SCALE,
      CSR_OFS_X,
      CSR_OFS_Y,
      CSR_OFS_Z,
      CSR_CENTER
   } csr_index_type;

   typedef logic [TERM_W-1:0] term_type;
   typedef term_type [2:0][2:0] matrix_type;

   // Static view settings seen by the front and back ends
   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [PT_W-1:0]    offset_x;
      logic [PT_W-1:0]    offset_y;
      logic [PT_W-1:0]    offset_z;
      logic [SCR_W-1:0]   center_x;
      logic [SCR_W-1:0]   center_y;
   } cfg_type;

   // Transformed vertex waiting for projection
   typedef struct packed {
      logic [V_W-1:0] v_x;
      logic [V_W-1:0] v_y;
      logic [V_W-1:0] v_z;
      logic           visible;
   } item_type;

endpackage

[hw/rtl/vrp_matrix.sv]
// ---------------------------------------------------------------------------
// vrp_matrix: rotation matrix builder
// Builds the nine Q2.14 axis-angle terms from axis, cosine and sine over a
// three-stage pipeline; busy while a rebuild is in flight.
// ---------------------------------------------------------------------------
module vrp_matrix
   import vrp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CSR_W-1:0]   axis,
   input  logic [TERM_W-1:0]  cos_angle,
   input  logic [TERM_W-1:0]  sin_angle,
   output matrix_type         matrix,
   output logic               busy
);

   localparam int P_W   = 32;
   localparam int OMC_W = 17;
   localparam int T_W   = P_W + OMC_W;
   localparam int TSH   = 28;
   localparam int USH   = 14;
   localparam int RT_W  = T_W - TSH;
   localparam int UR_W  = P_W - USH;
   localparam int S_W   = 23;

   logic signed [TERM_W-1:0] a_s [3];
   logic signed [TERM_W-1:0] cos_s, sin_s;

   logic signed [P_W-1:0]    pij_ff [3][3];
   logic signed [P_W-1:0]    pij_in [3][3];
   logic signed [P_W-1:0]    u_ff [3];
   logic signed [P_W-1:0]    u_in [3];
   logic signed [OMC_W-1:0]  omc_ff, omc_in;
   logic signed [TERM_W-1:0] c_ff, c2_ff;
   logic signed [T_W-1:0]    t_ff [3][3];
   logic signed [T_W-1:0]    t_in [3][3];
   logic signed [P_W-1:0]    u2_ff [3];
   matrix_type               m_ff, m_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   assign cos_s = $signed(cos_angle);
   assign sin_s = $signed(sin_angle);

   // Axis components: x in the top field
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_s[k] = $signed(axis[(2-k)*TERM_W +: TERM_W]);
      end
   end

   // Stage 1: axis products, sine products, one minus cosine
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pij_in[i][j] = a_s[i] * a_s[j];
         end
         u_in[i] = a_s[i] * sin_s;
      end
      omc_in = OMC_W'(ONE_Q14) - OMC_W'(cos_s);
   end

   // Stage 2: scale axis products by one minus cosine
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            t_in[i][j] = pij_ff[i][j] * omc_ff;
         end
      end
   end

   // Stage 3: round, add diagonal or sine part, saturate
   always_comb begin
      logic signed [T_W-1:0]  tr;
      logic signed [RT_W-1:0] rt;
      logic signed [P_W-1:0]  ut;
      logic signed [UR_W-1:0] ur [3];
      logic signed [S_W-1:0]  sum;
      int                     k;
      for (int n = 0; n < 3; n++) begin
         ut    = u2_ff[n] + (P_W'(1) <<< (USH - 1));
         ur[n] = $signed(ut[P_W-1:USH]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tr = t_ff[i][j] + (T_W'(1) <<< (TSH - 1));
            rt = $signed(tr[T_W-1:TSH]);
            k  = (i == j) ? 0 : 3 - i - j;
            if (i == j) begin
               sum = c2_ff + rt;
            end else if (j == (i + 2) % 3) begin
               sum = rt + ur[k];
            end else begin
               sum = rt - ur[k];
            end
            if (sum > S_W'(S16_MAX)) begin
               m_in[i][j] = TERM_W'(S16_MAX);
            end else if (sum < S_W'(S16_MIN)) begin
               m_in[i][j] = TERM_W'(S16_MIN);
            end else begin
               m_in[i][j] = sum[TERM_W-1:0];
            end
         end
      end
   end

   // Free-running pipeline registers
   always_ff @(posedge clock) begin
      pij_ff <= pij_in;
      u_ff   <= u_in;
      omc_ff <= omc_in;
      c_ff   <= cos_s;
      t_ff   <= t_in;
      u2_ff  <= u_ff;
      c2_ff  <= c_ff;
      m_ff   <= m_in;
   end

   // Rebuild counter, also armed by reset
   always_comb begin
      if (start) begin
         cnt_in = CNT_W'(SETUP_CYCLES);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(SETUP_CYCLES);
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign matrix = m_ff;
   assign busy   = (cnt_ff != '0);

endmodule

[hw/rtl/vrp_front.sv]
// ---------------------------------------------------------------------------
// vrp_front: transform front end
// Accepts vertices, rotates, scales and offsets them, and tags each with
// its visibility before handing it to the queue.
// ---------------------------------------------------------------------------
module vrp_front
   import vrp_pkg::*;
#(
   parameter int NEAR_DEPTH = NEAR_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_push,
   input  logic signed [PT_W-1:0] in_x,
   input  logic signed [PT_W-1:0] in_y,
   input  logic signed [PT_W-1:0] in_z,
   output logic                   in_ready,
   input  cfg_type                cfg,
   input  matrix_type             matrix,
   input  logic                   setup_busy,
   input  logic                   q_full,
   output logic                   q_push,
   output item_type               q_item
);

   localparam logic signed [V_W-1:0] NEAR_Q = V_W'(NEAR_DEPTH << PT_FRAC);

   logic                     adv, accept;
   logic signed [PT_W-1:0]   p_ff [3];
   logic                     p_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic signed [ACC_W-1:0]  acc_in [3];
   logic                     acc_valid_ff;
   logic signed [SC_W-1:0]   sc_ff [3];
   logic signed [SC_W-1:0]   sc_in [3];
   logic                     sc_valid_ff;
   logic signed [SCALE_W:0]  scale_s;
   logic signed [PT_W-1:0]   off_s [3];
   logic signed [V_W-1:0]    v_in [3];
   item_type                 item_ff, item_in;
   logic                     item_valid_ff;

   // The whole pipe holds while the last stage cannot enter the queue
   assign adv      = !(item_valid_ff && q_full);
   assign in_ready = adv && !setup_busy;
   assign accept   = in_push && in_ready;
   assign q_push   = item_valid_ff && !q_full;
   assign q_item   = item_ff;

   assign scale_s  = $signed({1'b0, cfg.scale});
   assign off_s[0] = $signed(cfg.offset_x);
   assign off_s[1] = $signed(cfg.offset_y);
   assign off_s[2] = $signed(cfg.offset_z);

   // Matrix lanes, row sums, scale
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(matrix[i][j]) * p_ff[j];
         end
         acc_in[i] = prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2];
         sc_in[i]  = acc_ff[i] * scale_s;
      end
   end

   // Round, subtract view offset, classify depth
   always_comb begin
      logic signed [SC_W-1:0] rnd;
      for (int i = 0; i < 3; i++) begin
         rnd     = sc_ff[i] + (SC_W'(1) <<< (VSHIFT - 1));
         v_in[i] = $signed(rnd[SC_W-1:VSHIFT]) - off_s[i];
      end
      item_in.v_x     = v_in[0];
      item_in.v_y     = v_in[1];
      item_in.v_z     = v_in[2];
      item_in.visible = (v_in[2] > NEAR_Q);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff    <= 1'b0;
         prod_valid_ff <= 1'b0;
         acc_valid_ff  <= 1'b0;
         sc_valid_ff   <= 1'b0;
         item_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff    <= accept;
         prod_valid_ff <= p_valid_ff;
         acc_valid_ff  <= prod_valid_ff;
         sc_valid_ff   <= acc_valid_ff;
         item_valid_ff <= sc_valid_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= in_x;
         p_ff[1] <= in_y;
         p_ff[2] <= in_z;
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
         sc_ff   <= sc_in;
         item_ff <= item_in;
      end
   end

endmodule

[hw/rtl/vrp_fifo.sv]
// ---------------------------------------------------------------------------
// vrp_fifo: front to back queue
// Short register queue that lets front and back end stall independently.
// ---------------------------------------------------------------------------
module vrp_fifo
   import vrp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_item,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_item,
   output logic     empty
);

   item_type          entry_ff [Q_DEPTH];
   logic [QA_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QA_W:0]     count_ff, count_in;

   assign full    = (count_ff == (QA_W+1)'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_item = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + (QA_W+1)'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - (QA_W+1)'(1);
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + QA_W'(1);
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + QA_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QA_W+1)'(Q_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("queue read while empty");

endmodule

[hw/rtl/vrp_div.sv]
// ---------------------------------------------------------------------------
// vrp_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, with a side tag and the
// divisor carried alongside each request.
// ---------------------------------------------------------------------------
module vrp_div
   import vrp_pkg::*;
#(
   parameter int DVD_W = A_W,
   parameter int DSR_W = DS_W,
   parameter int TAG_W = 1
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [DVD_W-1:0] in_dividend,
   input  logic [DSR_W-1:0] in_divisor,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [DVD_W-1:0] out_quotient,
   output logic [DSR_W-1:0] out_remainder,
   output logic [DSR_W-1:0] out_divisor,
   output logic [TAG_W-1:0] out_tag
);

   logic             val_ff [DVD_W];
   logic [DSR_W-1:0] rem_ff [DVD_W];
   logic [DVD_W-1:0] dvd_ff [DVD_W];
   logic [DSR_W-1:0] dsr_ff [DVD_W];
   logic [TAG_W-1:0] tag_ff [DVD_W];

   for (genvar s = 0; s < DVD_W; s++) begin : g_step
      logic             val_prev;
      logic [DSR_W-1:0] rem_prev, dsr_prev, rem_in;
      logic [DVD_W-1:0] dvd_prev, dvd_in;
      logic [TAG_W-1:0] tag_prev;
      logic [DSR_W:0]   trial, diff;
      logic             ge;

      if (s == 0) begin : g_first
         assign val_prev = in_valid;
         assign rem_prev = '0;
         assign dvd_prev = in_dividend;
         assign dsr_prev = in_divisor;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign val_prev = val_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign dvd_prev = dvd_ff[s-1];
         assign dsr_prev = dsr_ff[s-1];
         assign tag_prev = tag_ff[s-1];
      end

      // Shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial  = {rem_prev, dvd_prev[DVD_W-1]};
         diff   = trial - {1'b0, dsr_prev};
         ge     = (trial >= {1'b0, dsr_prev});
         rem_in = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         dvd_in = {dvd_prev[DVD_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[s] <= 1'b0;
         end else if (enable) begin
            val_ff[s] <= val_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            dvd_ff[s] <= dvd_in;
            dsr_ff[s] <= dsr_prev;
            tag_ff[s] <= tag_prev;
         end
      end
   end

   assign out_valid     = val_ff[DVD_W-1];
   assign out_quotient  = dvd_ff[DVD_W-1];
   assign out_remainder = rem_ff[DVD_W-1];
   assign out_divisor   = dsr_ff[DVD_W-1];
   assign out_tag       = tag_ff[DVD_W-1];

endmodule

[hw/rtl/vrp_back.sv]
// ---------------------------------------------------------------------------
// vrp_back: projection back end
// Takes transformed vertices from the queue, divides by depth in two
// divider lanes and forms saturated screen coordinates in the result
// register.
// ---------------------------------------------------------------------------
module vrp_back
   import vrp_pkg::*;
#(
   parameter int NEAR_DEPTH = NEAR_DEPTH_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  item_type                q_item,
   output logic                    q_pop,
   input  cfg_type                 cfg,
   output logic                    out_empty,
   input  logic                    out_pop,
   output logic signed [SCR_W-1:0] out_x,
   output logic signed [SCR_W-1:0] out_y,
   output logic                    out_visible
);

   localparam int F_W = A_W + 2;
   localparam int Q_W = F_W + 1;
   localparam logic signed [NEAR_W:0] NEAR_POS = (NEAR_W+1)'(NEAR_DEPTH);
   localparam logic signed [NEAR_W:0] NEAR_NEG = (NEAR_W+1)'(-NEAR_DEPTH);

   logic                    adv;
   logic signed [A_W-1:0]   a_x, a_y;
   logic [A_W-1:0]          mx_ff, my_ff;
   logic                    sx_ff, sy_ff, vis_ff, b0_valid_ff;
   logic [DS_W-1:0]         z_ff;
   logic                    dx_valid, dy_valid;
   logic [A_W-1:0]          dx_quot, dy_quot;
   logic [DS_W-1:0]         dx_rem, dy_rem, dx_dsr, dy_dsr;
   logic [1:0]              dx_tag;
   logic                    dy_tag;
   logic                    out_valid_ff;
   logic signed [SCR_W-1:0] out_x_ff, out_y_ff;
   logic                    out_vis_ff;

   // Floor quotient, center shift, then round toward zero and saturate
   function automatic logic [SCR_W-1:0] proj_fix(
      input logic [A_W-1:0]   q_mag,
      input logic [DS_W-1:0]  r,
      input logic [DS_W-1:0]  z,
      input logic             neg,
      input logic [SCR_W-1:0] c
   );
      logic signed [F_W-1:0] fq;
      logic [DS_W-1:0]       fr;
      logic signed [Q_W-1:0] q;
      logic                  nz;
      nz = (r != '0);
      if (!neg) begin
         fq = $signed({2'b00, q_mag});
         fr = r;
      end else begin
         fq = -$signed({2'b00, q_mag}) - $signed({{(F_W-1){1'b0}}, nz});
         fr = nz ? z - r : '0;
      end
      q = fq + $signed({{(Q_W-SCR_W){1'b0}}, c});
      if (q < 0 && fr != '0) begin
         q = q + Q_W'(1);
      end
      if (q > Q_W'(S16_MAX)) begin
         proj_fix = SCR_W'(S16_MAX);
      end else if (q < Q_W'(S16_MIN)) begin
         proj_fix = SCR_W'(S16_MIN);
      end else begin
         proj_fix = q[SCR_W-1:0];
      end
   endfunction

   assign adv   = !out_valid_ff || out_pop;
   assign q_pop = adv && !q_empty;

   // Numerators: NEAR*x for columns, -NEAR*y for rows
   assign a_x = $signed(q_item.v_x) * NEAR_POS;
   assign a_y = $signed(q_item.v_y) * NEAR_NEG;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
      end else if (adv) begin
         b0_valid_ff <= !q_empty;
      end
   end

   // Sign and magnitude split ahead of the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff  <= a_x[A_W-1];
         sy_ff  <= a_y[A_W-1];
         mx_ff  <= a_x[A_W-1] ? A_W'(-a_x) : A_W'(a_x);
         my_ff  <= a_y[A_W-1] ? A_W'(-a_y) : A_W'(a_y);
         z_ff   <= q_item.v_z[DS_W-1:0];
         vis_ff <= q_item.visible;
      end
   end

   vrp_div #(
      .DVD_W (A_W),
      .DSR_W (DS_W),
      .TAG_W (2)
   ) u_div_x (
      .clock         (clock),
      .reset         (reset),
      .enable        (adv),
      .in_valid      (b0_valid_ff),
      .in_dividend   (mx_ff),
      .in_divisor    (z_ff),
      .in_tag        ({vis_ff, sx_ff}),
      .out_valid     (dx_valid),
      .out_quotient  (dx_quot),
      .out_remainder (dx_rem),
      .out_divisor   (dx_dsr),
      .out_tag       (dx_tag)
   );

   vrp_div #(
      .DVD_W (A_W),
      .DSR_W (DS_W),
      .TAG_W (1)
   ) u_div_y (
      .clock         (clock),
      .reset         (reset),
      .enable        (adv),
      .in_valid      (b0_valid_ff),
      .in_dividend   (my_ff),
      .in_divisor    (z_ff),
      .in_tag        (sy_ff),
      .out_valid     (dy_valid),
      .out_quotient  (dy_quot),
      .out_remainder (dy_rem),
      .out_divisor   (dy_dsr),
      .out_tag       (dy_tag)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_vis_ff <= dx_tag[1];
         if (dx_tag[1]) begin
            out_x_ff <= proj_fix(dx_quot, dx_rem, dx_dsr, dx_tag[0], cfg.center_x);
            out_y_ff <= proj_fix(dy_quot, dy_rem, dy_dsr, dy_tag, cfg.center_y);
         end else begin
            out_x_ff <= '0;
            out_y_ff <= '0;
         end
      end
   end

   assign out_empty   = !out_valid_ff;
   assign out_x       = out_x_ff;
   assign out_y       = out_y_ff;
   assign out_visible = out_vis_ff;

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dx_valid == dy_valid)
      else $error("divider lanes out of step");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_vis_ff) |-> (out_x_ff == '0 && out_y_ff == '0))
      else $error("hidden vertex with nonzero coordinates");

endmodule

[hw/rtl/vertex_rotate_project_core.sv]
// ---------------------------------------------------------------------------
// vertex_rotate_project_core: rotate, scale, offset and project vertices
// Register file, matrix builder, transform front end, queue and
// projection back end.
// ---------------------------------------------------------------------------
// Path: an accepted request passes the five transform stages, the queue,
//   the sign split, the 55-stage depth divider and the result register.
// Throughput: one request per cycle while req_full is low, one result per
//   cycle while rsp_pop is high.
// Reset: clears the pipe and queue and loads register defaults; req_full
//   stays high after reset and each register write while the matrix rebuilds.
module vertex_rotate_project_core
   import vrp_pkg::*;
#(
   parameter int NEAR_DEPTH = NEAR_DEPTH_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic signed [PT_W-1:0]  req_point_x,
   input  logic signed [PT_W-1:0]  req_point_y,
   input  logic signed [PT_W-1:0]  req_point_z,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [SCR_W-1:0] rsp_screen_x,
   output logic signed [SCR_W-1:0] rsp_screen_y,
   output logic                    rsp_visible,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   logic [CSR_W-1:0]  axis_ff;
   logic [TERM_W-1:0] cos_ff, sin_ff;
   cfg_type           cfg_ff;
   matrix_type        matrix;
   logic              setup_busy;
   logic              front_ready;
   logic              q_push, q_full, q_pop, q_empty;
   item_type          q_wr_item, q_rd_item;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff         <= CSR_W'(ONE_Q14);
         cos_ff          <= TERM_W'(ONE_Q14);
         sin_ff          <= '0;
         cfg_ff.scale    <= SCALE_W'(1 << PT_FRAC);
         cfg_ff.offset_x <= '0;
         cfg_ff.offset_y <= '0;
         cfg_ff.offset_z <= '0;
         cfg_ff.center_x <= '0;
         cfg_ff.center_y <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_AXIS:   axis_ff         <= csr_wdata;
            CSR_COS:    cos_ff          <= csr_wdata[TERM_W-1:0];
            CSR_SIN:    sin_ff          <= csr_wdata[TERM_W-1:0];
            CSR_SCALE:  cfg_ff.scale    <= csr_wdata[SCALE_W-1:0];
            CSR_OFS_X:  cfg_ff.offset_x <= csr_wdata[PT_W-1:0];
            CSR_OFS_Y:  cfg_ff.offset_y <= csr_wdata[PT_W-1:0];
            CSR_OFS_Z:  cfg_ff.offset_z <= csr_wdata[PT_W-1:0];
            CSR_CENTER: begin
               cfg_ff.center_x <= csr_wdata[2*SCR_W-1:SCR_W];
               cfg_ff.center_y <= csr_wdata[SCR_W-1:0];
            end
            default: ;
         endcase
      end
   end

   vrp_matrix u_matrix (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_we),
      .axis       (axis_ff),
      .cos_angle  (cos_ff),
      .sin_angle  (sin_ff),
      .matrix     (matrix),
      .busy       (setup_busy)
   );

   vrp_front #(
      .NEAR_DEPTH (NEAR_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_push    (req_push),
      .in_x       (req_point_x),
      .in_y       (req_point_y),
      .in_z       (req_point_z),
      .in_ready   (front_ready),
      .cfg        (cfg_ff),
      .matrix     (matrix),
      .setup_busy (setup_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_wr_item)
   );

   vrp_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (q_wr_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_item (q_rd_item),
      .empty   (q_empty)
   );

   vrp_back #(
      .NEAR_DEPTH (NEAR_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_item      (q_rd_item),
      .q_pop       (q_pop),
      .cfg         (cfg_ff),
      .out_empty   (rsp_empty),
      .out_pop     (rsp_pop),
      .out_x       (rsp_screen_x),
      .out_y       (rsp_screen_y),
      .out_visible (rsp_visible)
   );

   assign req_full = !front_ready;

   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_full)
      else $error("request taken during matrix rebuild");

endmodule

[bench/vertex_rotate_project_core_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vertex_rotate_project_core_tb: self-checking bench for the vertex core
// Streams vertices through the core under several view settings and idle
// patterns. Each expected screen result is worked out from the settings in
// force and compared field by field with what the core returns.
// ---------------------------------------------------------------------------
module vertex_rotate_project_core_tb;
   import vrp_pkg::*;

   localparam int NEAR      = 100;
   localparam int LIMIT     = 400000;
   localparam int DRAIN_CYC = 80;

   typedef struct {
      logic signed [PT_W-1:0] x;
      logic signed [PT_W-1:0] y;
      logic signed [PT_W-1:0] z;
   } vertex_type;

   typedef struct {
      logic signed [SCR_W-1:0] sx;
      logic signed [SCR_W-1:0] sy;
      logic                    vis;
   } pixel_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic signed [PT_W-1:0]  req_point_x = '0;
   logic signed [PT_W-1:0]  req_point_y = '0;
   logic signed [PT_W-1:0]  req_point_z = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic signed [SCR_W-1:0] rsp_screen_x;
   logic signed [SCR_W-1:0] rsp_screen_y;
   logic                    rsp_visible;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   vertex_rotate_project_core dut (.*);

   // View settings mirror
   logic [47:0]        v_axis;
   logic signed [15:0] v_cos, v_sin;
   logic [15:0]        v_scale;
   logic signed [23:0] v_ofs [3];
   logic [31:0]        v_center;

   vertex_type pending_vertices[$];
   pixel_type  expected_pixels[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_active = 1'b0;
   int      mismatches = 0;
   int      checked = 0;
   int      visible_seen = 0;
   int      cycles = 0;

   initial forever #5 clock = ~clock;

   function automatic longint round_sh(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clamp16(longint v);
      return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
   endfunction

   function automatic longint rot_term(longint diag, longint ai, longint aj, longint omc,
                                       longint ak, bit plus);
      longint t, u;
      t = diag + round_sh(ai * aj * omc, 28);
      u = round_sh(ak * longint'(v_sin), 14);
      t = plus ? t + u : t - u;
      return clamp16(t);
   endfunction

   // Expected projection of one vertex under the current settings
   function automatic pixel_type project_vertex(vertex_type p);
      longint a[3], m[3][3], pt[3], v[3], c, omc, cx, cy, acc;
      pixel_type r;
      a[0] = longint'($signed(v_axis[47:32]));
      a[1] = longint'($signed(v_axis[31:16]));
      a[2] = longint'($signed(v_axis[15:0]));
      c = longint'(v_cos);
      omc = 16384 - c;
      m[0][0] = rot_term(c, a[0], a[0], omc, 0, 1'b1);
      m[0][1] = rot_term(0, a[0], a[1], omc, a[2], 1'b0);
      m[0][2] = rot_term(0, a[0], a[2], omc, a[1], 1'b1);
      m[1][0] = rot_term(0, a[1], a[0], omc, a[2], 1'b1);
      m[1][1] = rot_term(c, a[1], a[1], omc, 0, 1'b1);
      m[1][2] = rot_term(0, a[1], a[2], omc, a[0], 1'b0);
      m[2][0] = rot_term(0, a[2], a[0], omc, a[1], 1'b0);
      m[2][1] = rot_term(0, a[2], a[1], omc, a[0], 1'b1);
      m[2][2] = rot_term(c, a[2], a[2], omc, 0, 1'b1);
      pt[0] = longint'(p.x); pt[1] = longint'(p.y); pt[2] = longint'(p.z);
      for (int i = 0; i < 3; i++) begin
         acc = m[i][0] * pt[0] + m[i][1] * pt[1] + m[i][2] * pt[2];
         v[i] = round_sh(acc * longint'(v_scale), 22) - longint'(v_ofs[i]);
      end
      r = '{0, 0, 1'b0};
      if (v[2] > NEAR * 256) begin
         cx = longint'(v_center[31:16]);
         cy = longint'(v_center[15:0]);
         // SV division truncates toward zero
         r.sx = SCR_W'(clamp16((cx * v[2] + NEAR * v[0]) / v[2]));
         r.sy = SCR_W'(clamp16((cy * v[2] - NEAR * v[1]) / v[2]));
         r.vis = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint exp);
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp, checked);
      mismatches++;
   endtask

   // Request driver
   always @(posedge clock) begin
      vertex_type n;
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_pixels.push_back(project_vertex(pending_vertices.pop_front()));
         end
         if ((req_push && !req_full) || !req_push) begin
            if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               n = pending_vertices[0];
               req_push    <= 1'b1;
               req_point_x <= n.x;
               req_point_y <= n.y;
               req_point_z <= n.z;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      pixel_type e;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_visible !== e.vis) report_mismatch("visible", rsp_visible, e.vis);
               if (rsp_screen_x !== e.sx) report_mismatch("screen_x", rsp_screen_x, e.sx);
               if (rsp_screen_y !== e.sy) report_mismatch("screen_y", rsp_screen_y, e.sy);
               if (e.vis) visible_seen++;
            end
            checked++;
         end
         if (hold_active) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver hold-off, counted in cycles
   task automatic hold_receiver(int n);
      hold_active = 1'b1;
      repeat (n) @(posedge clock);
      hold_active = 1'b0;
   endtask

   task automatic write_reg(csr_index_type idx, logic [47:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AXIS:   v_axis = val;
         CSR_COS:    v_cos = val[15:0];
         CSR_SIN:    v_sin = val[15:0];
         CSR_SCALE:  v_scale = val[15:0];
         CSR_OFS_X:  v_ofs[0] = val[23:0];
         CSR_OFS_Y:  v_ofs[1] = val[23:0];
         CSR_OFS_Z:  v_ofs[2] = val[23:0];
         CSR_CENTER: v_center = val[31:0];
         default: ;
      endcase
   endtask

   task automatic add_vertex(int x, int y, int z);
      vertex_type n;
      n.x = PT_W'(x); n.y = PT_W'(y); n.z = PT_W'(z);
      pending_vertices.push_back(n);
   endtask

   // Wait for every request to come back, then for the pipe to settle
   task automatic drain;
      while (pending_vertices.size() > 0 || expected_pixels.size() > 0 || req_push)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // Mostly in-front vertices at moderate range, some full-range noise
   task automatic add_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            add_vertex($urandom, $urandom, $urandom);
         else
            add_vertex($signed($urandom_range(400000)) - 200000,
                       $signed($urandom_range(400000)) - 200000,
                       $urandom_range(600000, 20000));
      end
   endtask

   initial begin
      v_axis = 48'h4000; v_cos = 16384; v_sin = 0; v_scale = 256;
      v_ofs[0] = 0; v_ofs[1] = 0; v_ofs[2] = 0; v_center = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes and the near-plane boundary
      write_reg(CSR_CENTER, {16'd320, 16'd240});
      add_vertex(0, 0, 0);
      add_vertex(8388607, 8388607, 8388607);
      add_vertex(-8388608, -8388608, -8388608);
      add_vertex(-8388608, 8388607, 8388607);
      add_vertex(100, -100, NEAR * 256);
      add_vertex(100, -100, NEAR * 256 + 1);
      add_vertex(8388607, -8388608, NEAR * 256 + 1);
      add_vertex(-8388608, 8388607, NEAR * 256 + 1);
      add_vertex(25600, 25600, 51200);
      add_vertex(-1, -1, -1);
      drain();

      // Rotation about a tilted axis, scale and offsets, center at extremes
      write_reg(CSR_AXIS, {16'd9459, 16'd9459, 16'd9459});
      write_reg(CSR_COS, 16'd11585);
      write_reg(CSR_SIN, 16'd11585);
      write_reg(CSR_SCALE, 16'hFFFF);
      write_reg(CSR_OFS_X, 24'h800000);
      write_reg(CSR_OFS_Y, 24'h7FFFFF);
      write_reg(CSR_OFS_Z, 24'h800000);
      write_reg(CSR_CENTER, 32'hFFFF_FFFF);
      add_vertex(0, 0, 0);
      add_vertex(8388607, -8388608, 8388607);
      add_vertex(-8388608, 8388607, -8388608);
      add_vertex(1000, 2000, -3000);
      drain();

      // Non-normalized axis saturates the terms; negative cos/sin extremes
      write_reg(CSR_AXIS, 48'h7FFF_8000_7FFF);
      write_reg(CSR_COS, -16'sd16384);
      write_reg(CSR_SIN, -16'sd16384);
      write_reg(CSR_SCALE, 16'd0);
      write_reg(CSR_OFS_Z, -24'sd30000);
      write_reg(CSR_CENTER, 32'd0);
      add_vertex(8388607, 8388607, 8388607);
      add_vertex(-8388608, -8388608, -8388608);
      drain();

      // Random phases across settings and idle mixes
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_AXIS, ph == 0 ? 48'h4000 : 48'({$urandom, $urandom}));
         write_reg(CSR_COS, $urandom_range(32768) - 16384);
         write_reg(CSR_SIN, $urandom_range(32768) - 16384);
         write_reg(CSR_SCALE, ph == 3 ? $urandom : $urandom_range(512, 64));
         write_reg(CSR_OFS_X, $urandom_range(20000) - 10000);
         write_reg(CSR_OFS_Y, $urandom_range(20000) - 10000);
         write_reg(CSR_OFS_Z, ph == 3 ? $urandom : $urandom_range(20000) - 10000);
         write_reg(CSR_CENTER, $urandom);
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         // Long receiver hold-off while requests keep coming
         if (ph == 0) begin
            fork
               hold_receiver(200);
            join_none
         end
         add_random(145);
         drain();
      end

      $display("checked %0d results (%0d visible) over several view settings and idle mixes",
               checked, visible_seen);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
